// ----- sv/sincos_pkg.sv -----
// Shared types, constants and float helpers for the sine/cosine unit.
// No dependencies; used by sincos_fmul, sincos_fadd and the top level.
package sincos_pkg;

   // Single-precision constants as raw bit patterns
   localparam logic [31:0] FOUR_OVER_PI = 32'h3FA2F983;
   localparam logic [31:0] SPLIT_A      = 32'h3F490000;
   localparam logic [31:0] SPLIT_B      = 32'h397DA000;
   localparam logic [31:0] SPLIT_C      = 32'h33222169;
   localparam logic [31:0] ARG_LIMIT    = 32'h4B7FFFFF;
   localparam logic [31:0] SIN_C0       = 32'hBE2AAAA3;
   localparam logic [31:0] SIN_C1       = 32'h3C08839E;
   localparam logic [31:0] SIN_C2       = 32'hB94CA1F9;
   localparam logic [31:0] COS_C0       = 32'h3D2AAAA5;
   localparam logic [31:0] COS_C1       = 32'hBAB6061A;
   localparam logic [31:0] COS_C2       = 32'h37CCF5CE;
   localparam logic [31:0] NEG_HALF     = 32'hBF000000;
   localparam logic [31:0] FLT_ONE      = 32'h3F800000;
   localparam logic [31:0] QNAN         = 32'h7FC00000;

   // Side data that rides along with each request through the pipeline
   typedef struct packed {
      logic        valid;
      logic        err;
      logic        neg;
      logic        flip;
      logic        swap;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] yb;
      logic [31:0] yc;
      logic [31:0] r;
      logic [31:0] z;
   } ctx_type;

   // Significand with hidden bit
   function automatic logic [23:0] sig24(input logic [31:0] f);
      return {f[30:23] != 8'd0, f[22:0]};
   endfunction

   // Effective biased exponent (subnormals use 1)
   function automatic logic [7:0] exp_eff(input logic [31:0] f);
      return (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
   endfunction

   // Leading zero count of a 51-bit word (51 when zero)
   function automatic logic [5:0] lzc51(input logic [50:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd51;
      found = 1'b0;
      for (int i = 50; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(50 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Round to nearest even and pack; norm has its leading one at bit 50
   function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] be,
                                              input logic [50:0] norm);
      logic [101:0]       w;
      logic signed [11:0] tmp;
      logic [6:0]         sh;
      logic [23:0]        m;
      logic               g;
      logic               st;
      logic               rnd;
      logic [7:0]         ef;
      logic [30:0]        mag;
      tmp = 12'sd1 - be;
      if (be > 12'sd0) begin
         sh = 7'd0;
         ef = be[7:0];
      end else begin
         sh = (tmp > 12'sd52) ? 7'd52 : tmp[6:0];
         ef = 8'd0;
      end
      w   = {norm, 51'b0} >> sh;
      m   = w[101:78];
      g   = w[77];
      st  = |w[76:0];
      rnd = g & (st | m[0]);
      mag = {ef, m[22:0]} + 31'(rnd);
      return (norm == 51'd0) ? {s, 31'b0} : {s, mag};
   endfunction

endpackage

// ----- sv/sincos_fmul.sv -----
// Three-stage single-precision multiplier: multiply, leading-zero count, round.
// Depends on sincos_pkg; carries a ctx_type word alongside each product.
module sincos_fmul (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   input  sincos_pkg::ctx_type ctx_in,
   output logic [31:0]         p,
   output sincos_pkg::ctx_type ctx_out
);
   import sincos_pkg::*;

   logic               sign1_ff, sign2_ff;
   logic signed [11:0] exp1_ff, exp2_ff;
   logic [47:0]        prod1_ff, prod2_ff;
   logic [5:0]         lz2_ff;
   logic [31:0]        res3_ff;
   ctx_type            ctx1_ff, ctx2_ff, ctx3_ff;
   logic signed [11:0] exp1_in;
   logic [5:0]         lz2_in;
   logic [31:0]        res3_in;
   logic [47:0]        shifted;

   // Stage 1: significand product and exponent sum
   assign exp1_in = 12'(signed'({4'b0, exp_eff(a)})) + 12'(signed'({4'b0, exp_eff(b)}))
                    - 12'sd126;

   // Stage 2: normalize distance
   assign lz2_in = lzc51({prod1_ff, 3'b0});

   // Stage 3: normalize and round
   always_comb begin
      shifted = prod2_ff << lz2_ff;
      res3_in = round_pack(sign2_ff, exp2_ff - 12'(signed'({6'b0, lz2_ff})), {shifted, 3'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx1_ff <= '0;
         ctx2_ff <= '0;
         ctx3_ff <= '0;
      end else if (en) begin
         ctx1_ff <= ctx_in;
         ctx2_ff <= ctx1_ff;
         ctx3_ff <= ctx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign1_ff <= a[31] ^ b[31];
         exp1_ff  <= exp1_in;
         prod1_ff <= sig24(a) * sig24(b);
         sign2_ff <= sign1_ff;
         exp2_ff  <= exp1_ff;
         prod2_ff <= prod1_ff;
         lz2_ff   <= lz2_in;
         res3_ff  <= res3_in;
      end
   end

   assign p       = res3_ff;
   assign ctx_out = ctx3_ff;

endmodule

// ----- sv/sincos_fadd.sv -----
// Three-stage single-precision adder: align and add, leading-zero count, round.
// Depends on sincos_pkg; carries a ctx_type word alongside each sum.
module sincos_fadd (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   input  sincos_pkg::ctx_type ctx_in,
   output logic [31:0]         s,
   output sincos_pkg::ctx_type ctx_out
);
   import sincos_pkg::*;

   logic               sign1_ff, sign2_ff;
   logic signed [11:0] exp1_ff, exp2_ff;
   logic [50:0]        sum1_ff, sum2_ff;
   logic [5:0]         lz2_ff;
   logic [31:0]        res3_ff;
   ctx_type            ctx1_ff, ctx2_ff, ctx3_ff;

   logic [31:0]  big, sml;
   logic [7:0]   d;
   logic [5:0]   sh;
   logic [100:0] w;
   logic [50:0]  a_al, b_al;
   logic [50:0]  sum1_in;
   logic         sign1_in;
   logic [5:0]   lz2_in;
   logic [31:0]  res3_in;
   logic [50:0]  shifted;

   // Stage 1: order by magnitude, align the smaller operand, add or subtract
   always_comb begin
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      d    = exp_eff(big) - exp_eff(sml);
      sh   = (d > 8'd63) ? 6'd63 : d[5:0];
      w    = {sig24(sml), 26'b0, 51'b0} >> sh;
      a_al = {1'b0, sig24(big), 26'b0};
      b_al = {1'b0, w[100:51]} | {50'b0, |w[50:0]};
      if (a[31] == b[31]) sum1_in = a_al + b_al;
      else                sum1_in = a_al - b_al;
      sign1_in = (sum1_in == 51'd0) ? (a[31] & b[31]) : big[31];
   end

   // Stage 2: normalize distance
   assign lz2_in = lzc51(sum1_ff);

   // Stage 3: normalize and round
   always_comb begin
      shifted = sum2_ff << lz2_ff;
      res3_in = round_pack(sign2_ff, exp2_ff + 12'sd1 - 12'(signed'({6'b0, lz2_ff})), shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx1_ff <= '0;
         ctx2_ff <= '0;
         ctx3_ff <= '0;
      end else if (en) begin
         ctx1_ff <= ctx_in;
         ctx2_ff <= ctx1_ff;
         ctx3_ff <= ctx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sign1_ff <= sign1_in;
         exp1_ff  <= 12'(signed'({4'b0, exp_eff(big)}));
         sum1_ff  <= sum1_in;
         sign2_ff <= sign1_ff;
         exp2_ff  <= exp1_ff;
         sum2_ff  <= sum1_ff;
         lz2_ff   <= lz2_in;
         res3_ff  <= res3_in;
      end
   end

   assign s       = res3_ff;
   assign ctx_out = ctx3_ff;

endmodule

// ----- sv/float_sine_cosine_unit_core.sv -----
// Single-precision sine/cosine unit, fully pipelined.
// Pipeline: 14 float ranks, octant and quadrant stages, output register.
// Throughput: one request per cycle; a stalled result freezes the whole pipe.
// Reset: synchronous, clears all valid bits; no clearing pass.
// Depends on sincos_pkg, sincos_fmul and sincos_fadd.
module float_sine_cosine_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_angle_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sine_bits,
   output logic [31:0] rsp_cosine_bits,
   output logic        rsp_range_error
);
   import sincos_pkg::*;

   logic        adv;
   ctx_type     ctx_a_in, ctx_a, ctx_b_in, ctx_b, ctx_c_in, ctx_c, ctx_d, ctx_e;
   ctx_type     ctx_f_in, ctx_f, ctx_g_in, ctx_g, ctx_h, ctx_i, ctx_j, ctx_k, ctx_l, ctx_m, ctx_n;
   ctx_type     q_ctx_ff, y_ctx_ff, y_ctx_in;
   logic [25:0] q_oct_ff, q_oct_in;
   logic [31:0] scaled, ya, yb, yc, r1, r2, r3, z;
   logic [31:0] cg, sg, ch, sh, ci, si, cj, sj, ck, sk, cl, sl, cm, sm, cn, sn;
   logic        rsp_valid_ff;
   logic [31:0] sine_ff, cosine_ff, sine_in, cosine_in;
   logic        err_ff;

   // Whole pipeline moves when the output register can take a result
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      ctx_a_in       = '0;
      ctx_a_in.valid = req_valid;
      ctx_a_in.neg   = req_angle_bits[31];
      ctx_a_in.x     = {1'b0, req_angle_bits[30:0]};
      ctx_a_in.err   = {1'b0, req_angle_bits[30:0]} >= ARG_LIMIT;
   end

   // scaled = |x| * 4/pi
   sincos_fmul u_scale (.clock, .reset, .en(adv), .a(FOUR_OVER_PI), .b(ctx_a_in.x),
                        .ctx_in(ctx_a_in), .p(scaled), .ctx_out(ctx_a));

   // Octant by truncation
   always_comb begin
      logic [7:0]  e;
      logic [23:0] m;
      e = scaled[30:23];
      m = {1'b1, scaled[22:0]};
      if (e < 8'd127)      q_oct_in = 26'd0;
      else if (e <= 8'd150) q_oct_in = 26'(m >> (8'd150 - e));
      else                 q_oct_in = {2'b0, m} << (e - 8'd150);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ctx_ff <= '0;
         y_ctx_ff <= '0;
      end else if (adv) begin
         q_ctx_ff <= ctx_a;
         y_ctx_ff <= y_ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) q_oct_ff <= q_oct_in;
   end

   // Even quadrant count, its float value, and the fold flags
   always_comb begin
      logic [26:0] sum;
      logic [26:0] v;
      logic [5:0]  lz;
      logic [26:0] nv;
      sum      = {1'b0, q_oct_ff} + 27'd1;
      v        = {sum[26:1], 1'b0};
      lz       = lzc51({v, 24'b0});
      nv       = v << lz;
      y_ctx_in = q_ctx_ff;
      y_ctx_in.flip = sum[2];
      y_ctx_in.swap = sum[1];
      y_ctx_in.y    = (v == 27'd0) ? 32'd0 : {1'b0, 8'(8'd153 - {2'b0, lz}), nv[25:3]};
   end

   // y times the three parts of pi/4
   sincos_fmul u_ya (.clock, .reset, .en(adv), .a(y_ctx_ff.y), .b(SPLIT_A),
                     .ctx_in(y_ctx_ff), .p(ya), .ctx_out(ctx_b));
   sincos_fmul u_yb (.clock, .reset, .en(adv), .a(y_ctx_ff.y), .b(SPLIT_B),
                     .ctx_in(y_ctx_ff), .p(yb), .ctx_out());
   sincos_fmul u_yc (.clock, .reset, .en(adv), .a(y_ctx_ff.y), .b(SPLIT_C),
                     .ctx_in(y_ctx_ff), .p(yc), .ctx_out());

   always_comb begin
      ctx_b_in    = ctx_b;
      ctx_b_in.yb = yb;
      ctx_b_in.yc = yc;
   end

   // Three-part argument reduction
   sincos_fadd u_r1 (.clock, .reset, .en(adv), .a(ctx_b_in.x), .b({~ya[31], ya[30:0]}),
                     .ctx_in(ctx_b_in), .s(r1), .ctx_out(ctx_c));
   sincos_fadd u_r2 (.clock, .reset, .en(adv), .a(r1), .b({~ctx_c.yb[31], ctx_c.yb[30:0]}),
                     .ctx_in(ctx_c), .s(r2), .ctx_out(ctx_d));
   sincos_fadd u_r3 (.clock, .reset, .en(adv), .a(r2), .b({~ctx_d.yc[31], ctx_d.yc[30:0]}),
                     .ctx_in(ctx_d), .s(r3), .ctx_out(ctx_e));

   always_comb begin
      ctx_c_in   = ctx_e;
      ctx_c_in.r = r3;
   end

   // z = r * r
   sincos_fmul u_z (.clock, .reset, .en(adv), .a(r3), .b(r3),
                    .ctx_in(ctx_c_in), .p(z), .ctx_out(ctx_f));

   always_comb begin
      ctx_f_in   = ctx_f;
      ctx_f_in.z = z;
      ctx_g_in   = ctx_f_in;
   end

   // Polynomial ranks, cosine lane carries the context
   sincos_fmul u_cg (.clock, .reset, .en(adv), .a(COS_C2), .b(z),
                     .ctx_in(ctx_g_in), .p(cg), .ctx_out(ctx_g));
   sincos_fmul u_sg (.clock, .reset, .en(adv), .a(SIN_C2), .b(z),
                     .ctx_in(ctx_g_in), .p(sg), .ctx_out());

   sincos_fadd u_ch (.clock, .reset, .en(adv), .a(cg), .b(COS_C1),
                     .ctx_in(ctx_g), .s(ch), .ctx_out(ctx_h));
   sincos_fadd u_sh (.clock, .reset, .en(adv), .a(sg), .b(SIN_C1),
                     .ctx_in(ctx_g), .s(sh), .ctx_out());

   sincos_fmul u_ci (.clock, .reset, .en(adv), .a(ch), .b(ctx_h.z),
                     .ctx_in(ctx_h), .p(ci), .ctx_out(ctx_i));
   sincos_fmul u_si (.clock, .reset, .en(adv), .a(sh), .b(ctx_h.z),
                     .ctx_in(ctx_h), .p(si), .ctx_out());

   sincos_fadd u_cj (.clock, .reset, .en(adv), .a(ci), .b(COS_C0),
                     .ctx_in(ctx_i), .s(cj), .ctx_out(ctx_j));
   sincos_fadd u_sj (.clock, .reset, .en(adv), .a(si), .b(SIN_C0),
                     .ctx_in(ctx_i), .s(sj), .ctx_out());

   sincos_fmul u_ck (.clock, .reset, .en(adv), .a(cj), .b(ctx_j.z),
                     .ctx_in(ctx_j), .p(ck), .ctx_out(ctx_k));
   sincos_fmul u_sk (.clock, .reset, .en(adv), .a(sj), .b(ctx_j.z),
                     .ctx_in(ctx_j), .p(sk), .ctx_out());

   sincos_fadd u_cl (.clock, .reset, .en(adv), .a(ck), .b(NEG_HALF),
                     .ctx_in(ctx_k), .s(cl), .ctx_out(ctx_l));
   sincos_fadd u_sl (.clock, .reset, .en(adv), .a(sk), .b(FLT_ONE),
                     .ctx_in(ctx_k), .s(sl), .ctx_out());

   sincos_fmul u_cm (.clock, .reset, .en(adv), .a(cl), .b(ctx_l.z),
                     .ctx_in(ctx_l), .p(cm), .ctx_out(ctx_m));
   sincos_fmul u_sm (.clock, .reset, .en(adv), .a(sl), .b(ctx_l.r),
                     .ctx_in(ctx_l), .p(sm), .ctx_out());

   // Final cosine add; sine lane held by an exact multiply by one
   sincos_fadd u_cn (.clock, .reset, .en(adv), .a(cm), .b(FLT_ONE),
                     .ctx_in(ctx_m), .s(cn), .ctx_out(ctx_n));
   sincos_fmul u_sn (.clock, .reset, .en(adv), .a(sm), .b(FLT_ONE),
                     .ctx_in(ctx_m), .p(sn), .ctx_out());

   // Quadrant swap, sign fixes and range error
   always_comb begin
      if (ctx_n.err) begin
         sine_in   = QNAN;
         cosine_in = QNAN;
      end else if (ctx_n.swap) begin
         sine_in   = cn ^ {ctx_n.flip ^ ctx_n.neg, 31'b0};
         cosine_in = sn ^ {~ctx_n.flip, 31'b0};
      end else begin
         sine_in   = sn ^ {ctx_n.flip ^ ctx_n.neg, 31'b0};
         cosine_in = cn ^ {ctx_n.flip, 31'b0};
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctx_n.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
         err_ff    <= ctx_n.err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sine_bits   = sine_ff;
   assign rsp_cosine_bits = cosine_ff;
   assign rsp_range_error = err_ff;

endmodule
